>>> sv/cso_pkg.sv
package cso_pkg;

  // Form geometry and coordinate width.
  localparam int CursorSize = 16;
  localparam int CoordBits  = 12;
  localparam int IdxBits    = $clog2(CursorSize);
  localparam int DiffBits   = CoordBits + 2;

  // Fixed field widths of the channels.
  localparam int PixCoordW = 12;
  localparam int FormRowW  = 16;
  localparam int RowIdxW   = 4;
  localparam int HotW      = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 4;

  typedef enum logic [1:0] {
    ModePixel = 2'd0,
    ModeLoad  = 2'd1,
    ModeMove  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHotX        = 3'd0,
    CfgHotY        = 3'd1,
    CfgFgColor     = 3'd2,
    CfgBgColor     = 3'd3,
    CfgCursorHidden = 3'd4,
    CfgDisplayOpen = 3'd5
  } cfg_idx_e;

  typedef logic [CursorSize-1:0] form_row_t;

  // One accepted input request as held in the input stage.
  typedef struct packed {
    logic [1:0]           mode;
    logic [PixCoordW-1:0] pix_x;
    logic [PixCoordW-1:0] pix_y;
    logic                 fb_pixel;
    logic [RowIdxW-1:0]   row_index;
    logic [FormRowW-1:0]  mask_row;
    logic [FormRowW-1:0]  data_row;
    logic [PixCoordW-1:0] pointer_x;
    logic [PixCoordW-1:0] pointer_y;
  } in_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [HotW-1:0] hot_x;
    logic [HotW-1:0] hot_y;
    logic            fore_pix;
    logic            back_pix;
    logic            overlay_off;
    logic            display_open;
  } cfg_t;

  // Write request into the form store.
  typedef struct packed {
    logic               en;
    logic [IdxBits-1:0] idx;
    form_row_t          mask;
    form_row_t          data;
  } form_wr_t;

  // Built-in arrow, 16 rows of 16 bits, bit 15 is column 0.
  localparam logic [FormRowW-1:0] ArrowMask [16] = '{
    16'hc000, 16'he000, 16'hf000, 16'hf800, 16'hfc00, 16'hfe00, 16'hff00, 16'hff80,
    16'hffc0, 16'hffe0, 16'hfe00, 16'hef00, 16'hcf00, 16'h8780, 16'h0780, 16'h0380
  };
  localparam logic [FormRowW-1:0] ArrowData [16] = '{
    16'h0000, 16'h4000, 16'h6000, 16'h7000, 16'h7800, 16'h7c00, 16'h7e00, 16'h7f00,
    16'h7f80, 16'h7c00, 16'h6c00, 16'h4600, 16'h0600, 16'h0300, 16'h0300, 16'h0000
  };

  // Places a 16-bit row so that its bit 15 lands on form column 0.
  function automatic form_row_t align_row(logic [FormRowW-1:0] v);
    logic [CursorSize+FormRowW-1:0] wide;
    wide = {v, {CursorSize{1'b0}}};
    return wide[CursorSize+FormRowW-1 -: CursorSize];
  endfunction

  // Reset contents of a form row; rows past the arrow are empty.
  function automatic form_row_t arrow_mask_row(int r);
    form_row_t row;
    row = '0;
    if (r < 16) begin
      row = align_row(ArrowMask[r]);
    end
    return row;
  endfunction

  function automatic form_row_t arrow_data_row(int r);
    form_row_t row;
    row = '0;
    if (r < 16) begin
      row = align_row(ArrowData[r]);
    end
    return row;
  endfunction

endpackage

>>> sv/cso_in_if.sv
interface cso_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [cso_pkg::PixCoordW-1:0]  pix_x;
  logic [cso_pkg::PixCoordW-1:0]  pix_y;
  logic                           fb_pixel;
  logic [cso_pkg::RowIdxW-1:0]    row_index;
  logic [cso_pkg::FormRowW-1:0]   mask_row;
  logic [cso_pkg::FormRowW-1:0]   data_row;
  logic [cso_pkg::PixCoordW-1:0]  pointer_x;
  logic [cso_pkg::PixCoordW-1:0]  pointer_y;

  modport source (
    output valid, mode, pix_x, pix_y, fb_pixel, row_index, mask_row, data_row,
           pointer_x, pointer_y,
    input  ready
  );
  modport sink (
    input  valid, mode, pix_x, pix_y, fb_pixel, row_index, mask_row, data_row,
           pointer_x, pointer_y,
    output ready
  );
endinterface

>>> sv/cso_out_if.sv
interface cso_out_if;
  logic valid;
  logic ready;
  logic out_pixel;
  logic in_cursor;

  modport source (output valid, out_pixel, in_cursor, input ready);
  modport sink (input valid, out_pixel, in_cursor, output ready);
endinterface

>>> sv/cso_cfg_if.sv
interface cso_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cso_pkg::CfgIdxW-1:0]   index;
  logic [cso_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

>>> sv/cso_cfg_regs.sv
module cso_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  cso_cfg_if.sink       cfg_i,
  output cso_pkg::cfg_t cfg_o
);

  cso_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes leave everything as is.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cso_pkg::cfg_idx_e'(cfg_i.index))
        cso_pkg::CfgHotX:         cfg_d.hot_x        = cfg_i.wdata[cso_pkg::HotW-1:0];
        cso_pkg::CfgHotY:         cfg_d.hot_y        = cfg_i.wdata[cso_pkg::HotW-1:0];
        cso_pkg::CfgFgColor:      cfg_d.fore_pix     = cfg_i.wdata[0];
        cso_pkg::CfgBgColor:      cfg_d.back_pix     = cfg_i.wdata[0];
        cso_pkg::CfgCursorHidden: cfg_d.overlay_off  = cfg_i.wdata[0];
        cso_pkg::CfgDisplayOpen:  cfg_d.display_open = cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hot_x        <= '0;
      cfg_q.hot_y        <= '0;
      cfg_q.fore_pix     <= 1'b0;
      cfg_q.back_pix     <= 1'b1;
      cfg_q.overlay_off  <= 1'b0;
      cfg_q.display_open <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/cso_form_store.sv
module cso_form_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cso_pkg::form_wr_t             wr_i,
  input  logic [cso_pkg::IdxBits-1:0]   rd_idx_i,
  output cso_pkg::form_row_t            rd_mask_o,
  output cso_pkg::form_row_t            rd_data_o
);

  cso_pkg::form_row_t mask_q [cso_pkg::CursorSize];
  cso_pkg::form_row_t data_q [cso_pkg::CursorSize];

  // Rows reset to the built-in arrow and are overwritten one row per load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < cso_pkg::CursorSize; r++) begin
        mask_q[r] <= cso_pkg::arrow_mask_row(r);
        data_q[r] <= cso_pkg::arrow_data_row(r);
      end
    end else if (wr_i.en) begin
      mask_q[wr_i.idx] <= wr_i.mask;
      data_q[wr_i.idx] <= wr_i.data;
    end
  end

  // Single read port, addressed by the row offset inside the box.
  assign rd_mask_o = mask_q[rd_idx_i];
  assign rd_data_o = data_q[rd_idx_i];

endmodule

>>> sv/cursor_sprite_overlay.sv
// A pixel request is held in the input stage, then its result is written into the
// result register. Throughput: one request per clock unless the result register
// is stalled; the path between the two registers is the box compare against the
// pointer origin and one form row lookup.
// Reset (rst_ni, asynchronous, active low) empties both stages, restores the
// register defaults, moves the pointer to 0,0 and reloads the built-in arrow form.
module cursor_sprite_overlay (
  input  logic     clk_i,
  input  logic     rst_ni,
  cso_in_if.sink   in_i,
  cso_out_if.source out_o,
  cso_cfg_if.sink  cfg_i
);

  localparam int CursorSize = cso_pkg::CursorSize;
  localparam int CoordBits  = cso_pkg::CoordBits;
  localparam int IdxBits    = cso_pkg::IdxBits;
  localparam int DiffBits   = cso_pkg::DiffBits;

  cso_pkg::cfg_t      cfg;
  cso_pkg::form_wr_t  form_wr;
  cso_pkg::form_row_t rd_mask;
  cso_pkg::form_row_t rd_data;

  cso_pkg::in_item_t  s0_item_q;
  logic               s0_valid_q;
  logic [CoordBits-1:0] pointer_col_q, pointer_row_q;
  logic               out_valid_q, out_pixel_q, in_cursor_q;

  logic s0_is_pixel, out_free, s0_fire, in_ready;

  cso_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: the input stage drains when its request needs no result slot
  // or the result register is free this cycle.
  assign s0_is_pixel = (cso_pkg::mode_e'(s0_item_q.mode) == cso_pkg::ModePixel);
  assign out_free    = !out_valid_q || out_o.ready;
  assign s0_fire     = s0_valid_q && (!s0_is_pixel || out_free);
  assign in_ready    = !s0_valid_q || s0_fire;
  assign in_i.ready  = in_ready;

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s0_item_q.mode      <= in_i.mode;
      s0_item_q.pix_x     <= in_i.pix_x;
      s0_item_q.pix_y     <= in_i.pix_y;
      s0_item_q.fb_pixel  <= in_i.fb_pixel;
      s0_item_q.row_index <= in_i.row_index;
      s0_item_q.mask_row  <= in_i.mask_row;
      s0_item_q.data_row  <= in_i.data_row;
      s0_item_q.pointer_x <= in_i.pointer_x;
      s0_item_q.pointer_y <= in_i.pointer_y;
    end
  end

  // Form row loads; rows past the form depth are dropped.
  always_comb begin
    form_wr.en   = s0_fire && (cso_pkg::mode_e'(s0_item_q.mode) == cso_pkg::ModeLoad)
                   && (int'(s0_item_q.row_index) < CursorSize);
    form_wr.idx  = IdxBits'(s0_item_q.row_index);
    form_wr.mask = cso_pkg::align_row(s0_item_q.mask_row);
    form_wr.data = cso_pkg::align_row(s0_item_q.data_row);
  end

  // Pointer position register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_col_q <= '0;
      pointer_row_q <= '0;
    end else if (s0_fire && (cso_pkg::mode_e'(s0_item_q.mode) == cso_pkg::ModeMove)) begin
      pointer_col_q <= CoordBits'(s0_item_q.pointer_x);
      pointer_row_q <= CoordBits'(s0_item_q.pointer_y);
    end
  end

  // Offsets from the box origin (pointer minus hot spot, may be negative).
  logic [DiffBits-1:0] org_x, org_y, dx, dy;
  logic                in_box, cursor_on, mask_bit, data_bit, hit, pix;
  logic [IdxBits-1:0]  col;

  assign org_x = DiffBits'(pointer_col_q) - DiffBits'(cfg.hot_x);
  assign org_y = DiffBits'(pointer_row_q) - DiffBits'(cfg.hot_y);
  assign dx    = DiffBits'(CoordBits'(s0_item_q.pix_x)) - org_x;
  assign dy    = DiffBits'(CoordBits'(s0_item_q.pix_y)) - org_y;

  assign in_box = !dx[DiffBits-1] && (dx[DiffBits-2:0] < (DiffBits-1)'(CursorSize))
               && !dy[DiffBits-1] && (dy[DiffBits-2:0] < (DiffBits-1)'(CursorSize));
  assign cursor_on = cfg.display_open && !cfg.overlay_off;

  cso_form_store u_form_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (form_wr),
    .rd_idx_i  (dy[IdxBits-1:0]),
    .rd_mask_o (rd_mask),
    .rd_data_o (rd_data)
  );

  // The most significant bit of a row is column 0.
  assign col      = dx[IdxBits-1:0];
  assign mask_bit = rd_mask[IdxBits'(CursorSize-1) - col];
  assign data_bit = rd_data[IdxBits'(CursorSize-1) - col];
  assign hit      = cursor_on && in_box && mask_bit;
  assign pix      = hit ? (data_bit ? cfg.fore_pix : cfg.back_pix) : s0_item_q.fb_pixel;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_fire && s0_is_pixel) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire && s0_is_pixel) begin
      out_pixel_q <= pix;
      in_cursor_q <= hit;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_pixel_q;
  assign out_o.in_cursor = in_cursor_q;

  // A new result only ever comes from a pixel request leaving the input stage.
  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s0_valid_q && s0_is_pixel))
    else $error("result appeared without a pixel request");

  // A request that cannot drain stays in the input stage unchanged.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !s0_fire) |=> (s0_valid_q && $stable(s0_item_q)))
    else $error("input stage lost or changed a stalled request");

  // A pixel blocked by a full result register keeps the input closed.
  a_block_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && s0_is_pixel && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while a pixel was blocked");

endmodule
